FILE: rtl/core/tphc_pkg.sv
package tphc_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_CAL_A   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_CAL_B   = 3'd5;
    localparam int unsigned CFG_DATA_W = 64;

    // Pipeline stage numbers; stage 0 is the input capture stage.
    localparam int unsigned ST_T_MUL    = 1;
    localparam int unsigned ST_T_MUL2   = 2;
    localparam int unsigned ST_T_FINE   = 3;
    localparam int unsigned ST_T_OUT    = 4;
    localparam int unsigned ST_MUL_A    = 5;
    localparam int unsigned ST_MUL_B    = 6;
    localparam int unsigned ST_SUM_A    = 7;
    localparam int unsigned ST_DEN      = 8;
    localparam int unsigned ST_NUM      = 9;
    localparam int unsigned ST_DIV_PREP = 10;
    localparam int unsigned ST_H_SQ     = 11;
    localparam int unsigned ST_H_MUL    = 12;
    localparam int unsigned ST_H_OUT    = 13;
    localparam int unsigned DIV_STEPS   = 32;
    localparam int unsigned DIV_FIRST   = 11;
    localparam int unsigned DIV_LAST    = DIV_FIRST + DIV_STEPS - 1;
    localparam int unsigned ST_P_QUO    = DIV_LAST + 1;
    localparam int unsigned ST_P_MUL    = DIV_LAST + 2;
    localparam int unsigned ST_P_MUL2   = DIV_LAST + 3;
    localparam int unsigned ST_P_OUT    = DIV_LAST + 4;
    localparam int unsigned NUM_STAGES  = ST_P_OUT + 1;

    localparam logic [31:0] P_OFFSET   = 32'd64000;
    localparam logic [31:0] H_OFFSET   = 32'd76800;
    localparam logic [31:0] P_BASE     = 32'd1048576;
    localparam logic [31:0] P_SCALE    = 32'd3125;
    localparam logic [31:0] HUM_MAX    = 32'd419430400;
    localparam logic [31:0] K_2097152  = 32'd2097152;
    localparam logic [31:0] K_32768    = 32'd32768;
    localparam logic [31:0] K_16384    = 32'd16384;
    localparam logic [31:0] K_8192     = 32'd8192;

    // Calibration words, already extended to 32 bits.
    typedef struct packed {
        logic [31:0] t1, t2, t3;
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
    } cal_t;

    // Everything an item carries down the pipeline.
    typedef struct packed {
        logic [19:0] adc_p;
        logic [19:0] adc_t;
        logic [15:0] adc_h;
        logic [31:0] a1m, dm, ta, db, tf, temp, pa, hv;
        logic [31:0] q, ma5, mp2, mh5, mv6, mv3, xa;
        logic [31:0] b0, m3, x, y1, y2, b, a2, my;
        logic [31:0] den, pn, my2, pnum, y, dividend, rem, quo;
        logic        dbl;
        logic        dz;
        logic [31:0] vh, sq, sh;
        logic [16:0] hum;
        logic [31:0] p, m9a, mb, m9, press;
    } item_t;

    function automatic logic [31:0] sra(logic [31:0] v, int unsigned n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
        logic [31:0] r;
        r = a * b;
        return r;
    endfunction

    // Work done by one pipeline stage.
    function automatic item_t stage_fn(item_t s, cal_t c, int unsigned idx);
        item_t       r;
        logic [32:0] rw;
        logic [31:0] at;
        logic [31:0] d;
        logic [31:0] vf;
        r  = s;
        rw = '0;
        at = 32'(s.adc_t);
        d  = '0;
        vf = '0;
        if (idx >= DIV_FIRST && idx <= DIV_LAST)
        begin
            // One restoring division step.
            rw = {s.rem, s.dividend[31]};
            r.dividend = {s.dividend[30:0], 1'b0};
            if (rw >= {1'b0, s.den})
            begin
                rw = rw - {1'b0, s.den};
                r.quo = {s.quo[30:0], 1'b1};
            end
            else
            begin
                r.quo = {s.quo[30:0], 1'b0};
            end
            r.rem = rw[31:0];
        end
        if (idx == ST_T_MUL)
        begin
            r.a1m = mul32((at >> 3) - (c.t1 << 1), c.t2);
            d = (at >> 4) - c.t1;
            r.dm = mul32(d, d);
        end
        else if (idx == ST_T_MUL2)
        begin
            r.ta = sra(s.a1m, 11);
            r.db = mul32(sra(s.dm, 12), c.t3);
        end
        else if (idx == ST_T_FINE)
        begin
            r.tf = s.ta + sra(s.db, 14);
        end
        else if (idx == ST_T_OUT)
        begin
            r.temp = sra(mul32(s.tf, 32'd5) + 32'd128, 8);
            r.pa   = sra(s.tf, 1) - P_OFFSET;
            r.hv   = s.tf - H_OFFSET;
        end
        else if (idx == ST_MUL_A)
        begin
            r.q   = mul32(sra(s.pa, 2), sra(s.pa, 2));
            r.ma5 = mul32(s.pa, c.p5);
            r.mp2 = mul32(c.p2, s.pa);
            r.mh5 = mul32(c.h5, s.hv);
            r.mv6 = mul32(s.hv, c.h6);
            r.mv3 = mul32(s.hv, c.h3);
            r.xa  = (32'(s.adc_h) << 14) - (c.h4 << 20);
        end
        else if (idx == ST_MUL_B)
        begin
            r.b0 = mul32(sra(s.q, 11), c.p6);
            r.m3 = mul32(c.p3, sra(s.q, 13));
            r.x  = sra(s.xa - s.mh5 + K_16384, 15);
            r.y1 = sra(s.mv6, 10);
            r.y2 = sra(s.mv3, 11) + K_32768;
        end
        else if (idx == ST_SUM_A)
        begin
            r.b  = sra(s.b0 + (s.ma5 << 1), 2) + (c.p4 << 16);
            r.a2 = sra(sra(s.m3, 3) + sra(s.mp2, 1), 18);
            r.my = mul32(s.y1, s.y2);
        end
        else if (idx == ST_DEN)
        begin
            r.den = sra(mul32(K_32768 + s.a2, c.p1), 15);
            r.pn  = (P_BASE - 32'(s.adc_p)) - sra(s.b, 12);
            r.my2 = mul32(sra(s.my, 10) + K_2097152, c.h2);
        end
        else if (idx == ST_NUM)
        begin
            r.pnum = mul32(s.pn, P_SCALE);
            r.y    = sra(s.my2 + K_8192, 14);
        end
        else if (idx == ST_DIV_PREP)
        begin
            // Large numerators are divided first and doubled afterwards.
            r.dz       = (s.den == '0);
            r.dbl      = s.pnum[31];
            r.dividend = s.pnum[31] ? s.pnum : (s.pnum << 1);
            r.rem      = '0;
            r.quo      = '0;
            r.vh       = mul32(s.x, s.y);
        end
        if (idx == ST_H_SQ)
        begin
            r.sq = mul32(sra(s.vh, 15), sra(s.vh, 15));
        end
        else if (idx == ST_H_MUL)
        begin
            r.sh = mul32(sra(s.sq, 7), c.h1);
        end
        else if (idx == ST_H_OUT)
        begin
            // Clamp to 0..100 %RH before scaling down.
            vf = s.vh - sra(s.sh, 4);
            if (vf[31])
            begin
                vf = '0;
            end
            if (vf > HUM_MAX)
            begin
                vf = HUM_MAX;
            end
            r.hum = vf[28:12];
        end
        else if (idx == ST_P_QUO)
        begin
            r.p = s.dbl ? (s.quo << 1) : s.quo;
        end
        else if (idx == ST_P_MUL)
        begin
            r.m9a = mul32(s.p >> 3, s.p >> 3);
            r.mb  = mul32(s.p >> 2, c.p8);
        end
        else if (idx == ST_P_MUL2)
        begin
            r.m9 = mul32(c.p9, s.m9a >> 13);
        end
        else if (idx == ST_P_OUT)
        begin
            r.press = s.dz ? '0
                : s.p + sra(sra(s.m9, 12) + sra(s.mb, 13) + c.p7, 4);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/tphc_sample_if.sv
interface tphc_sample_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;

    modport source (output valid, raw_pressure, raw_temperature, raw_humidity,
                    input ready);
    modport sink (input valid, raw_pressure, raw_temperature, raw_humidity,
                  output ready);
endinterface

FILE: rtl/core/tphc_result_if.sv
interface tphc_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] temperature_centi;
    logic [31:0] pressure_pa;
    logic [16:0] humidity_q10;
    logic        pressure_div_zero;

    modport source (output valid, temperature_centi, pressure_pa, humidity_q10,
                    pressure_div_zero, input ready);
    modport sink (input valid, temperature_centi, pressure_pa, humidity_q10,
                  pressure_div_zero, output ready);
endinterface

FILE: rtl/core/temp_press_hum_compensation.sv
// Throughput: one item per cycle; the 32-step pipelined restoring divider
// for pressure sets the depth, and no stage chains more than one multiply.
// The whole pipeline holds while a finished result waits to be taken.
// Reset clears the stage valid bits and all calibration registers to zero.
module temp_press_hum_compensation (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tphc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tphc_pkg::CFG_DATA_W-1:0]    cfg_data,
    tphc_sample_if.sink                        samples,
    tphc_result_if.source                      results
);
    import tphc_pkg::*;

    logic [47:0] temp_cal_reg;
    logic [63:0] press_cal_a_reg;
    logic [63:0] press_cal_b_reg;
    logic [15:0] press_cal_c_reg;
    logic [31:0] hum_cal_a_reg;
    logic [31:0] hum_cal_b_reg;
    cal_t        cal;

    item_t                 st_reg  [NUM_STAGES];
    item_t                 st_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;
    logic                  adv;

    // Calibration register writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg    <= '0;
            press_cal_a_reg <= '0;
            press_cal_b_reg <= '0;
            press_cal_c_reg <= '0;
            hum_cal_a_reg   <= '0;
            hum_cal_b_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEMP_CAL:    temp_cal_reg    <= cfg_data[47:0];
                REG_PRESS_CAL_A: press_cal_a_reg <= cfg_data;
                REG_PRESS_CAL_B: press_cal_b_reg <= cfg_data;
                REG_PRESS_CAL_C: press_cal_c_reg <= cfg_data[15:0];
                REG_HUM_CAL_A:   hum_cal_a_reg   <= cfg_data[31:0];
                REG_HUM_CAL_B:   hum_cal_b_reg   <= cfg_data[31:0];
                default:         ;
            endcase
        end
    end

    // Unpack the calibration words with their signedness.
    always_comb
    begin
        cal.t1 = {16'd0, temp_cal_reg[15:0]};
        cal.t2 = 32'($signed(temp_cal_reg[31:16]));
        cal.t3 = 32'($signed(temp_cal_reg[47:32]));
        cal.p1 = {16'd0, press_cal_a_reg[15:0]};
        cal.p2 = 32'($signed(press_cal_a_reg[31:16]));
        cal.p3 = 32'($signed(press_cal_a_reg[47:32]));
        cal.p4 = 32'($signed(press_cal_a_reg[63:48]));
        cal.p5 = 32'($signed(press_cal_b_reg[15:0]));
        cal.p6 = 32'($signed(press_cal_b_reg[31:16]));
        cal.p7 = 32'($signed(press_cal_b_reg[47:32]));
        cal.p8 = 32'($signed(press_cal_b_reg[63:48]));
        cal.p9 = 32'($signed(press_cal_c_reg));
        cal.h1 = {24'd0, hum_cal_a_reg[7:0]};
        cal.h2 = 32'($signed(hum_cal_a_reg[23:8]));
        cal.h3 = {24'd0, hum_cal_a_reg[31:24]};
        cal.h4 = {20'd0, hum_cal_b_reg[11:0]};
        cal.h5 = {20'd0, hum_cal_b_reg[23:12]};
        cal.h6 = 32'($signed(hum_cal_b_reg[31:24]));
    end

    // The pipeline moves whenever the output stage is empty or being taken.
    assign adv           = !vld_reg[NUM_STAGES-1] || results.ready;
    assign samples.ready = adv;

    // Input capture stage.
    always_comb
    begin
        st_next[0]       = '0;
        st_next[0].adc_p = samples.raw_pressure;
        st_next[0].adc_t = samples.raw_temperature;
        st_next[0].adc_h = samples.raw_humidity;
    end

    // Stage logic.
    for (genvar i = 1; i < NUM_STAGES; i++)
    begin : g_stage
        assign st_next[i] = stage_fn(st_reg[i-1], cal, i);
    end

    // Valid bits travel with the items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], samples.valid};
        end
    end

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg <= st_next;
        end
    end

    // The last stage is the output register.
    assign results.valid             = vld_reg[NUM_STAGES-1];
    assign results.temperature_centi = st_reg[NUM_STAGES-1].temp;
    assign results.pressure_pa       = st_reg[NUM_STAGES-1].press;
    assign results.humidity_q10      = st_reg[NUM_STAGES-1].hum;
    assign results.pressure_div_zero = st_reg[NUM_STAGES-1].dz;

    // A zero divisor always forces a zero pressure.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.pressure_div_zero |-> results.pressure_pa == '0)
        else $error("pressure not zero on zero divisor");

    // Humidity stays inside the clamp range.
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.humidity_q10 <= 17'd102400)
        else $error("humidity beyond clamp");

    // Refusing input means a result was held, and it is still there.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |=> results.valid)
        else $error("result lost during stall");

    // An item in the second-to-last stage moves up when the pipeline advances.
    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[NUM_STAGES-2] |=> results.valid)
        else $error("item dropped between stages");

endmodule
